@@ rtl/rpr_pkg.sv @@
// ----------------------------------------------------------------------------
// rpr_pkg
// Types, constants and register codes of the rotary position rotation block.
// ----------------------------------------------------------------------------
package rpr_pkg;

    localparam int unsigned DEF_MAX_WIDTH    = 4096;
    localparam int unsigned DEF_MAX_POSITION = 4096;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_LANES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WIDTH  = 1'd1;
    localparam logic [8:0]  HEAD_LANES_RST = 9'd64;
    localparam logic [12:0] KEY_WIDTH_RST  = 13'd4096;

    localparam int unsigned QUEUE_DEPTH = 4;

    // Q32 constants
    localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
    localparam logic [35:0] LOG2_1E4    = 36'hD_49A7_84BC;
    localparam logic [31:0] LN2_Q32     = 32'hB172_17F8;
    localparam logic [29:0] INV2PI_Q32  = 30'h28BE_60DC;
    localparam logic [33:0] PI_Q32      = 34'h3_243F_6A88;
    localparam logic [29:0] QUARTER_PI  = 30'h2000_0000; // one octant of a turn

    // Horner divisors
    localparam int unsigned EXP_STEPS = 12;
    localparam int unsigned SIN_STEPS = 6;
    localparam int unsigned COS_STEPS = 7;
    localparam int unsigned EXP_DIV [EXP_STEPS] = '{12, 11, 10, 9, 8, 7, 6, 5, 4, 3, 2, 1};
    localparam int unsigned SIN_DIV [SIN_STEPS] = '{156, 110, 72, 42, 20, 6};
    localparam int unsigned COS_DIV [COS_STEPS] = '{182, 132, 90, 56, 30, 12, 2};

    typedef struct packed {
        logic [11:0]        lane;
        logic [11:0]        position;
        logic signed [31:0] q_first;
        logic signed [31:0] q_second;
        logic signed [31:0] k_first;
        logic signed [31:0] k_second;
    } rpr_in_t;

    typedef struct packed {
        logic signed [31:0] q_first_out;
        logic signed [31:0] q_second_out;
        logic signed [31:0] k_first_out;
        logic signed [31:0] k_second_out;
        logic               key_rotated;
    } rpr_out_t;

    // classified item, front to back
    typedef struct packed {
        logic [11:0]        lane;
        logic [8:0]         hs;
        logic [11:0]        pos;
        logic               lane_ok;
        logic               key_rot;
        logic signed [31:0] q_first;
        logic signed [31:0] q_second;
        logic signed [31:0] k_first;
        logic signed [31:0] k_second;
    } rpr_entry_t;

endpackage

@@ rtl/rpr_front.sv @@
// ----------------------------------------------------------------------------
// rpr_front
// Configuration registers and item classification ahead of the queue.
// ----------------------------------------------------------------------------
module rpr_front #(
    parameter int unsigned MAX_WIDTH    = rpr_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_POSITION = rpr_pkg::DEF_MAX_POSITION
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  rpr_pkg::rpr_in_t                 item,
    input  logic                             full,
    output logic                             push,
    output rpr_pkg::rpr_entry_t              entry
);
    import rpr_pkg::*;

    logic [8:0]  head_lanes_reg;
    logic [12:0] key_width_reg;
    logic        lane_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_lanes_reg <= HEAD_LANES_RST;
            key_width_reg  <= KEY_WIDTH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HEAD_LANES: head_lanes_reg <= cfg_data[8:0];
                REG_KEY_WIDTH:  key_width_reg  <= cfg_data;
                default:        head_lanes_reg <= head_lanes_reg;
            endcase
        end
    end

    assign item_stall = full;
    assign push       = item_valid && !full;
    assign lane_ok    = 32'(item.lane) < 32'(MAX_WIDTH);

    always_comb
    begin
        entry.lane     = item.lane;
        // zero head size behaves as one
        entry.hs       = (head_lanes_reg == 9'd0) ? 9'd1 : head_lanes_reg;
        entry.pos      = (32'(item.position) >= 32'(MAX_POSITION)) ?
                         12'(MAX_POSITION - 1) : item.position;
        entry.lane_ok  = lane_ok;
        entry.key_rot  = lane_ok && ({1'b0, item.lane} < key_width_reg);
        entry.q_first  = item.q_first;
        entry.q_second = item.q_second;
        entry.k_first  = item.k_first;
        entry.k_second = item.k_second;
    end

endmodule

@@ rtl/rpr_queue.sv @@
// ----------------------------------------------------------------------------
// rpr_queue
// Short queue between the classifier and the rotation pipeline.
// ----------------------------------------------------------------------------
module rpr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rpr_pkg::rpr_entry_t  entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output rpr_pkg::rpr_entry_t  head
);
    import rpr_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    rpr_entry_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full       = count_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= PTR_W'(wr_ptr_reg + 1'b1);
            if (pop)
                rd_ptr_reg <= PTR_W'(rd_ptr_reg + 1'b1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= entry;
    end

endmodule

@@ rtl/rpr_horner_step.sv @@
// ----------------------------------------------------------------------------
// rpr_horner_step
// One Horner step r' = 1 - floor(floor(v * r) / DIV), Q32, three stages.
// ----------------------------------------------------------------------------
module rpr_horner_step #(
    parameter int unsigned DIV = 1
) (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] v_in,
    input  logic [32:0] r_in,
    output logic [31:0] v_out,
    output logic [32:0] r_out
);
    import rpr_pkg::*;

    // floor(2^32 / DIV); estimate is low by at most one
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / DIV);
    localparam logic [7:0]  K     = 8'(DIV);

    logic [31:0] p1_reg, v1_reg;
    logic [31:0] p2_reg, v2_reg, qe2_reg;
    logic [64:0] prod1, prod2;
    logic [39:0] rem3;
    logic [31:0] q3;

    assign prod1 = v_in * r_in;
    assign prod2 = p1_reg * RECIP;
    assign rem3  = 40'(p2_reg) - qe2_reg * K;
    assign q3    = (rem3 >= 40'(K)) ? qe2_reg + 1'b1 : qe2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= prod1[63:32];
            v1_reg  <= v_in;
            p2_reg  <= p1_reg;
            qe2_reg <= prod2[63:32];
            v2_reg  <= v1_reg;
            r_out   <= ONE_Q32 - 33'(q3);
            v_out   <= v2_reg;
        end
    end

endmodule

@@ rtl/rpr_back.sv @@
// ----------------------------------------------------------------------------
// rpr_back
// Rotation pipeline: lane mod head size, exponent divide, exp, sin/cos,
// rotation and saturation. Advances as a whole unless the result is held.
// ----------------------------------------------------------------------------
module rpr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  rpr_pkg::rpr_entry_t  head,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output rpr_pkg::rpr_out_t    result
);
    import rpr_pkg::*;

    localparam int unsigned MD_STAGES = 3;   // 12 lane bits, 4 per stage
    localparam int unsigned DV_STAGES = 9;   // 36 quotient bits, 4 per stage
    localparam int unsigned STEP_BITS = 4;
    localparam int unsigned ST_NM   = MD_STAGES + 1;
    localparam int unsigned ST_Y    = ST_NM + DV_STAGES + 1;
    localparam int unsigned ST_EXP  = ST_Y + 3 * EXP_STEPS;
    localparam int unsigned ST_STEP = ST_EXP + 1;
    localparam int unsigned ST_PH   = ST_STEP + 1;
    localparam int unsigned ST_X    = ST_PH + 1;
    localparam int unsigned ST_X2   = ST_X + 1;
    localparam int unsigned ST_SIN  = ST_X2 + 3 * SIN_STEPS;
    localparam int unsigned ST_SN   = ST_SIN + 1;
    localparam int unsigned ST_COS  = ST_X2 + 3 * COS_STEPS;
    localparam int unsigned ST_CF   = ST_COS + 1;
    localparam int unsigned ST_PR   = ST_CF + 1;
    localparam int unsigned LAT     = ST_PR + 1;

    typedef struct packed {
        logic signed [31:0] q_first;
        logic signed [31:0] q_second;
        logic signed [31:0] k_first;
        logic signed [31:0] k_second;
        logic               lane_ok;
        logic               key_rot;
        logic [11:0]        pos;
        logic [3:0]         n;
        logic [2:0]         oct;
        logic [31:0]        x;
        logic [31:0]        sn;
    } rpr_side_t;

    function automatic logic [9:0] div_step(input logic [8:0] rem, input logic nb,
                                            input logic [8:0] hs);
        logic [9:0] e;
        e = {rem, nb};
        if (e >= {1'b0, hs})
            div_step = {1'b1, 9'(e - {1'b0, hs})};
        else
            div_step = {1'b0, e[8:0]};
    endfunction

    function automatic logic signed [31:0] scale_out(input logic signed [64:0] v);
        logic signed [64:0] r;
        r = (v + 65'sd536870912) >>> 30;
        if (r > 65'sd2147483647)
            scale_out = 32'sh7FFF_FFFF;
        else if (r < -65'sd2147483648)
            scale_out = 32'sh8000_0000;
        else
            scale_out = r[31:0];
    endfunction

    logic            en;
    logic [LAT:1]    vld_reg;
    rpr_side_t       sb_reg [1:LAT-1];
    rpr_side_t       head_side;

    assign en           = !(vld_reg[LAT] && result_stall);
    assign pop          = en && head_valid;
    assign result_valid = vld_reg[LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-1:1], head_valid};
    end

    always_comb
    begin
        head_side          = '0;
        head_side.q_first  = head.q_first;
        head_side.q_second = head.q_second;
        head_side.k_first  = head.k_first;
        head_side.k_second = head.k_second;
        head_side.lane_ok  = head.lane_ok;
        head_side.key_rot  = head.key_rot;
        head_side.pos      = head.pos;
    end

    // ---- d = lane mod head size ----
    logic [8:0]  md_rem_reg [MD_STAGES];
    logic [11:0] md_sh_reg  [MD_STAGES];
    logic [8:0]  md_hs_reg  [MD_STAGES];

    for (genvar g = 0; g < MD_STAGES; g++)
    begin : g_md
        logic [8:0]  rem_in, hs_in, r_c;
        logic [11:0] sh_in, sh_c;
        logic [9:0]  st_c;
        if (g == 0)
        begin : g_first
            assign rem_in = '0;
            assign sh_in  = head.lane;
            assign hs_in  = head.hs;
        end
        else
        begin : g_rest
            assign rem_in = md_rem_reg[g-1];
            assign sh_in  = md_sh_reg[g-1];
            assign hs_in  = md_hs_reg[g-1];
        end
        always_comb
        begin
            r_c  = rem_in;
            sh_c = sh_in;
            st_c = '0;
            for (int j = 0; j < STEP_BITS; j++)
            begin
                st_c = div_step(r_c, sh_c[11], hs_in);
                r_c  = st_c[8:0];
                sh_c = {sh_c[10:0], st_c[9]};
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                md_rem_reg[g] <= r_c;
                md_sh_reg[g]  <= sh_c;
                md_hs_reg[g]  <= hs_in;
            end
        end
    end

    // ---- t = d * log2(10000) / head size ----
    logic [44:0] nm_reg;
    logic [8:0]  nm_hs_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_reg    <= md_rem_reg[MD_STAGES-1] * LOG2_1E4;
            nm_hs_reg <= md_hs_reg[MD_STAGES-1];
        end
    end

    logic [8:0]  dv_rem_reg [DV_STAGES];
    logic [35:0] dv_sh_reg  [DV_STAGES];
    logic [8:0]  dv_hs_reg  [DV_STAGES];

    for (genvar g = 0; g < DV_STAGES; g++)
    begin : g_dv
        logic [8:0]  rem_in, hs_in, r_c;
        logic [35:0] sh_in, sh_c;
        logic [9:0]  st_c;
        if (g == 0)
        begin : g_first
            // top bits stay below head size since d < head size
            assign rem_in = nm_reg[44:36];
            assign sh_in  = nm_reg[35:0];
            assign hs_in  = nm_hs_reg;
        end
        else
        begin : g_rest
            assign rem_in = dv_rem_reg[g-1];
            assign sh_in  = dv_sh_reg[g-1];
            assign hs_in  = dv_hs_reg[g-1];
        end
        always_comb
        begin
            r_c  = rem_in;
            sh_c = sh_in;
            st_c = '0;
            for (int j = 0; j < STEP_BITS; j++)
            begin
                st_c = div_step(r_c, sh_c[35], hs_in);
                r_c  = st_c[8:0];
                sh_c = {sh_c[34:0], st_c[9]};
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[g] <= r_c;
                dv_sh_reg[g]  <= sh_c;
                dv_hs_reg[g]  <= hs_in;
            end
        end
    end

    // ---- exp(-frac * ln2) ----
    logic [31:0] y_reg;
    logic [63:0] y_prod;

    assign y_prod = dv_sh_reg[DV_STAGES-1][31:0] * LN2_Q32;

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= y_prod[63:32];
    end

    logic [31:0] ex_v [EXP_STEPS];
    logic [32:0] ex_r [EXP_STEPS+1];
    assign ex_v[0] = y_reg;
    assign ex_r[0] = ONE_Q32;

    for (genvar i = 0; i < EXP_STEPS; i++)
    begin : g_exp
        if (i < EXP_STEPS - 1)
        begin : g_mid
            rpr_horner_step #(.DIV(EXP_DIV[i])) u_step (
                .clk   (clk),
                .en    (en),
                .v_in  (ex_v[i]),
                .r_in  (ex_r[i]),
                .v_out (ex_v[i+1]),
                .r_out (ex_r[i+1])
            );
        end
        else
        begin : g_last
            rpr_horner_step #(.DIV(EXP_DIV[i])) u_step (
                .clk   (clk),
                .en    (en),
                .v_in  (ex_v[i]),
                .r_in  (ex_r[i]),
                .v_out (),
                .r_out (ex_r[i+1])
            );
        end
    end

    // ---- turns per position, phase ----
    logic [32:0] freq;
    logic [62:0] step_prod;
    logic [30:0] step_reg;
    logic [42:0] ph_prod;
    logic [31:0] phase_reg;

    assign freq      = ex_r[EXP_STEPS] >> sb_reg[ST_EXP].n;
    assign step_prod = freq * INV2PI_Q32;
    assign ph_prod   = sb_reg[ST_STEP].pos * step_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            step_reg  <= step_prod[62:32];
            phase_reg <= ph_prod[31:0];
        end
    end

    // ---- angle within one octant ----
    logic [2:0]  x_oct;
    logic [29:0] x_a;
    logic [63:0] x_prod;
    logic [31:0] x_val;
    logic [63:0] x2_prod;
    logic [31:0] x2_reg;

    assign x_oct  = phase_reg[31:29];
    assign x_a    = x_oct[0] ? QUARTER_PI - {1'b0, phase_reg[28:0]}
                             : {1'b0, phase_reg[28:0]};
    assign x_prod = x_a * PI_Q32;
    assign x_val  = x_prod[62:31];
    assign x2_prod = sb_reg[ST_X].x * sb_reg[ST_X].x;

    always_ff @(posedge clk)
    begin
        if (en)
            x2_reg <= x2_prod[63:32];
    end

    // ---- sin and cos series ----
    logic [31:0] sn_v [SIN_STEPS];
    logic [32:0] sn_r [SIN_STEPS+1];
    logic [31:0] cs_v [COS_STEPS];
    logic [32:0] cs_r [COS_STEPS+1];
    assign sn_v[0] = x2_reg;
    assign sn_r[0] = ONE_Q32;
    assign cs_v[0] = x2_reg;
    assign cs_r[0] = ONE_Q32;

    for (genvar i = 0; i < SIN_STEPS; i++)
    begin : g_sin
        if (i < SIN_STEPS - 1)
        begin : g_mid
            rpr_horner_step #(.DIV(SIN_DIV[i])) u_step (
                .clk   (clk),
                .en    (en),
                .v_in  (sn_v[i]),
                .r_in  (sn_r[i]),
                .v_out (sn_v[i+1]),
                .r_out (sn_r[i+1])
            );
        end
        else
        begin : g_last
            rpr_horner_step #(.DIV(SIN_DIV[i])) u_step (
                .clk   (clk),
                .en    (en),
                .v_in  (sn_v[i]),
                .r_in  (sn_r[i]),
                .v_out (),
                .r_out (sn_r[i+1])
            );
        end
    end

    for (genvar i = 0; i < COS_STEPS; i++)
    begin : g_cos
        if (i < COS_STEPS - 1)
        begin : g_mid
            rpr_horner_step #(.DIV(COS_DIV[i])) u_step (
                .clk   (clk),
                .en    (en),
                .v_in  (cs_v[i]),
                .r_in  (cs_r[i]),
                .v_out (cs_v[i+1]),
                .r_out (cs_r[i+1])
            );
        end
        else
        begin : g_last
            rpr_horner_step #(.DIV(COS_DIV[i])) u_step (
                .clk   (clk),
                .en    (en),
                .v_in  (cs_v[i]),
                .r_in  (cs_r[i]),
                .v_out (),
                .r_out (cs_r[i+1])
            );
        end
    end

    logic [64:0] sn_prod;
    logic [31:0] sn_val;

    assign sn_prod = sb_reg[ST_SIN].x * sn_r[SIN_STEPS];
    assign sn_val  = sn_prod[63:32];

    // ---- sideband line; fields filled in where they are produced ----
    for (genvar s = 1; s < LAT; s++)
    begin : g_sb
        rpr_side_t nx;
        if (s == 1)
        begin : g_first
            assign nx = head_side;
        end
        else
        begin : g_rest
            always_comb
            begin
                nx = sb_reg[s-1];
                if (s == ST_Y)
                    nx.n = dv_sh_reg[DV_STAGES-1][35:32];
                if (s == ST_X)
                begin
                    nx.oct = x_oct;
                    nx.x   = x_val;
                end
                if (s == ST_SN)
                    nx.sn = sn_val;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                sb_reg[s] <= nx;
        end
    end

    // ---- octant reflection, Q30 coefficients ----
    // cos of a zero angle is exactly one, so the coefficient reaches 2^30
    logic [2:0]         cf_oct;
    logic               cf_swap;
    logic [32:0]        cf_sv, cf_cv;
    logic [33:0]        cf_sr, cf_cr;
    logic signed [31:0] cf_s_reg, cf_c_reg;

    assign cf_oct  = sb_reg[ST_COS].oct;
    assign cf_swap = (cf_oct == 3'd1) || (cf_oct == 3'd2) || (cf_oct == 3'd5) ||
                     (cf_oct == 3'd6);
    assign cf_sv   = cf_swap ? cs_r[COS_STEPS] : {1'b0, sb_reg[ST_COS].sn};
    assign cf_cv   = cf_swap ? {1'b0, sb_reg[ST_COS].sn} : cs_r[COS_STEPS];
    assign cf_sr   = 34'(cf_sv) + 34'd2;
    assign cf_cr   = 34'(cf_cv) + 34'd2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cf_s_reg <= cf_oct[2] ? -signed'({1'b0, cf_sr[32:2]})
                                  : signed'({1'b0, cf_sr[32:2]});
            cf_c_reg <= (cf_oct >= 3'd2 && cf_oct <= 3'd5) ? -signed'({1'b0, cf_cr[32:2]})
                                                           : signed'({1'b0, cf_cr[32:2]});
        end
    end

    // ---- products ----
    logic signed [63:0] pr_reg [8];
    rpr_side_t          ps;

    assign ps = sb_reg[ST_CF];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg[0] <= ps.q_first  * cf_c_reg;
            pr_reg[1] <= ps.q_second * cf_s_reg;
            pr_reg[2] <= ps.q_first  * cf_s_reg;
            pr_reg[3] <= ps.q_second * cf_c_reg;
            pr_reg[4] <= ps.k_first  * cf_c_reg;
            pr_reg[5] <= ps.k_second * cf_s_reg;
            pr_reg[6] <= ps.k_first  * cf_s_reg;
            pr_reg[7] <= ps.k_second * cf_c_reg;
        end
    end

    // ---- round, saturate, pass-through ----
    rpr_side_t os;
    rpr_out_t  result_next;

    assign os = sb_reg[ST_PR];

    always_comb
    begin
        result_next.q_first_out  = scale_out(65'(pr_reg[0]) - 65'(pr_reg[1]));
        result_next.q_second_out = scale_out(65'(pr_reg[2]) + 65'(pr_reg[3]));
        result_next.k_first_out  = scale_out(65'(pr_reg[4]) - 65'(pr_reg[5]));
        result_next.k_second_out = scale_out(65'(pr_reg[6]) + 65'(pr_reg[7]));
        result_next.key_rotated  = os.key_rot;
        if (!os.lane_ok)
        begin
            result_next.q_first_out  = os.q_first;
            result_next.q_second_out = os.q_second;
        end
        if (!os.key_rot)
        begin
            result_next.k_first_out  = os.k_first;
            result_next.k_second_out = os.k_second;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result <= result_next;
    end

endmodule

@@ rtl/rotary_position_rotate.sv @@
// ----------------------------------------------------------------------------
// rotary_position_rotate
// Rotary position rotation of a query pair and key pair, signed Q16.16.
//
//   channel  direction  handshake              beat
//   item     in         item_valid/item_stall  rpr_in_t
//   result   out        result_valid/r._stall  rpr_out_t
//   cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item per cycle while the queue is not full. Pipeline depth is set by
// the pipelined lane divide, the exp series and the sin/cos series.
// The four-entry queue absorbs items while the pipeline is held by
// result_stall; item_stall rises only when that queue is full.
// Reset clears the queue and pipeline valids; registers take their defaults.
// ----------------------------------------------------------------------------
module rotary_position_rotate #(
    parameter int unsigned MAX_WIDTH    = rpr_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_POSITION = rpr_pkg::DEF_MAX_POSITION
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  rpr_pkg::rpr_in_t                 item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output rpr_pkg::rpr_out_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rpr_pkg::*;

    logic       push, full, pop, head_valid;
    rpr_entry_t entry, head;

    rpr_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_POSITION (MAX_POSITION)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .full       (full),
        .push       (push),
        .entry      (entry)
    );

    rpr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .entry      (entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    rpr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ rtl/rpr_check.sv @@
// ----------------------------------------------------------------------------
// rpr_check
// Port-level checks of the rotation block, bound to the top level.
// ----------------------------------------------------------------------------
module rpr_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  logic                             item_stall,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  rpr_pkg::rpr_out_t                result,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready
);

    // held result beat keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // queue only fills on an accepted beat
    a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_stall) |-> $past(item_valid && !item_stall))
        else $error("item_stall rose without an accepted beat");

    // queue only drains when the pipeline moves
    a_stall_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(item_stall) |-> $past(!(result_valid && result_stall)))
        else $error("item_stall fell while the pipeline was held");

    // config port never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("cfg write not taken");

endmodule

bind rotary_position_rotate rpr_check u_check (.*);

@@ tb/rotary_position_rotate_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_position_rotate_tb
// Streams query/key pairs through the rotary rotation block under several
// head size and key width settings. A scoreboard predicts every rotated pair
// in fixed point and checks each result beat in order. Both sides idle and
// stall at random, except under one quiet setting.
// ----------------------------------------------------------------------------
module rotary_position_rotate_tb;
    import rpr_pkg::*;

    localparam int unsigned IDLE_LIMIT = 5000;
    localparam int unsigned RAND_ITEMS = 305;

    localparam bit [63:0] Q32_UNIT  = 64'h1_0000_0000;
    localparam bit [63:0] LOW_WORD  = 64'hFFFF_FFFF;
    localparam bit [63:0] LOG2_TENK = 64'hD_49A7_84BC;
    localparam bit [63:0] LN_TWO    = 64'hB172_17F8;
    localparam bit [63:0] TURN_INV  = 64'h28BE_60DC;
    localparam bit [63:0] PI_FIX    = 64'h3_243F_6A88;
    localparam bit [63:0] OCTANT    = 64'h2000_0000;

    class rotation_scoreboard;
        bit [8:0]  head_lanes = HEAD_LANES_RST;
        bit [12:0] key_width = KEY_WIDTH_RST;
        rpr_out_t  pending_pairs[$];
        int        errors = 0;
        int        matched = 0;

        task report(string what, longint got, longint want);
            $display("MISMATCH %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        function bit [63:0] series(bit [63:0] v, bit sine);
            bit [63:0] r;
            int unsigned dv;
            r = Q32_UNIT;
            for (int i = 0; i < (sine ? 6 : 7); i++)
            begin
                case (i)
                    0: dv = sine ? 156 : 182;
                    1: dv = sine ? 110 : 132;
                    2: dv = sine ? 72 : 90;
                    3: dv = sine ? 42 : 56;
                    4: dv = sine ? 20 : 30;
                    5: dv = sine ? 6 : 12;
                    default: dv = 2;
                endcase
                r = Q32_UNIT - ((v * r) >> 32) / dv;
            end
            return r;
        endfunction

        function bit [31:0] round_sat(longint v);
            longint r;
            v = v + (longint'(1) <<< 29);
            if (v >= 0)
                r = v >>> 30;
            else
                r = -(((-v) + longint'(64'h3FFF_FFFF)) >>> 30);
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            return r[31:0];
        endfunction

        function rpr_out_t rotate_pair(rpr_in_t it);
            bit [63:0] hs, d, t, n, y, r, freq, step, phase, a, x, x2, sn, cs, tmp;
            bit [2:0]  oct;
            longint    c, s, q0, q1, k0, k1;
            rpr_out_t  o;
            hs = (head_lanes == 0) ? 64'd1 : 64'(head_lanes);
            d = 64'(it.lane) % hs;
            t = d * LOG2_TENK / hs;
            n = t >> 32;
            y = ((t & LOW_WORD) * LN_TWO) >> 32;
            r = Q32_UNIT;
            for (int k = 12; k >= 1; k--)
                r = Q32_UNIT - ((y * r) >> 32) / 64'(k);
            freq = (n < 40) ? (r >> n) : 64'd0;
            step = (freq * TURN_INV) >> 32;
            phase = (64'(it.position) * step) & LOW_WORD;
            oct = phase[31:29];
            a = phase & (OCTANT - 1);
            if (oct[0])
                a = OCTANT - a;
            x = (a * PI_FIX) >> 31;
            x2 = (x * x) >> 32;
            sn = (x * series(x2, 1'b1)) >> 32;
            cs = series(x2, 1'b0);
            if (oct == 1 || oct == 2 || oct == 5 || oct == 6)
            begin
                tmp = sn;
                sn = cs;
                cs = tmp;
            end
            s = longint'((sn + 2) >> 2);
            c = longint'((cs + 2) >> 2);
            if (oct >= 4)
                s = -s;
            if (oct >= 2 && oct <= 5)
                c = -c;
            q0 = it.q_first;
            q1 = it.q_second;
            k0 = it.k_first;
            k1 = it.k_second;
            o.q_first_out = round_sat(q0 * c - q1 * s);
            o.q_second_out = round_sat(q0 * s + q1 * c);
            if (13'(it.lane) < key_width)
            begin
                o.k_first_out = round_sat(k0 * c - k1 * s);
                o.k_second_out = round_sat(k0 * s + k1 * c);
                o.key_rotated = 1'b1;
            end
            else
            begin
                o.k_first_out = it.k_first;
                o.k_second_out = it.k_second;
                o.key_rotated = 1'b0;
            end
            return o;
        endfunction

        function void note_item(rpr_in_t it);
            pending_pairs.push_back(rotate_pair(it));
        endfunction

        task check_result(rpr_out_t got);
            rpr_out_t want;
            if (pending_pairs.size() == 0)
            begin
                report("unexpected beat", longint'(got), 0);
                return;
            end
            want = pending_pairs.pop_front();
            matched++;
            if (got.q_first_out !== want.q_first_out)
                report("q_first_out", got.q_first_out, want.q_first_out);
            if (got.q_second_out !== want.q_second_out)
                report("q_second_out", got.q_second_out, want.q_second_out);
            if (got.k_first_out !== want.k_first_out)
                report("k_first_out", got.k_first_out, want.k_first_out);
            if (got.k_second_out !== want.k_second_out)
                report("k_second_out", got.k_second_out, want.k_second_out);
            if (got.key_rotated !== want.key_rotated)
                report("key_rotated", got.key_rotated, want.key_rotated);
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    rpr_in_t               item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    rpr_out_t              result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_HEAD_LANES;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    rotation_scoreboard sb = new();
    bit quiet = 1'b0;
    int unsigned idle_cycles = 0;
    int sent = 0;
    int settings = 0;

    rotary_position_rotate dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_HEAD_LANES: sb.head_lanes = cfg_data[8:0];
                    REG_KEY_WIDTH:  sb.key_width = cfg_data;
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
                sb.note_item(item);
            if (result_valid && !result_stall)
                sb.check_result(result);
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("rotary_position_rotate_tb failed");
                $finish;
            end
        end
    end

    always @(negedge clk)
        result_stall = !quiet && ($urandom_range(99) < 34);

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task send(rpr_in_t it);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 34)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        item = it;
        do @(posedge clk); while (item_stall);
        sent++;
    endtask

    function logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(32'h0003_0000);   // small positive
            3: return -$urandom_range(32'h0003_0000);
            default: return $urandom;
        endcase
    endfunction

    task send_pair(logic [11:0] lane, logic [11:0] pos,
                   logic [31:0] q0, logic [31:0] q1, logic [31:0] k0, logic [31:0] k1);
        rpr_in_t it;
        it.lane = lane;
        it.position = pos;
        it.q_first = q0;
        it.q_second = q1;
        it.k_first = k0;
        it.k_second = k1;
        send(it);
    endtask

    task drain();
        @(negedge clk);
        item_valid = 1'b0;
        while (sb.pending_pairs.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task random_items(int count);
        logic [11:0] lane;
        for (int i = 0; i < count; i++)
        begin
            lane = ($urandom_range(3) == 0) ? 12'($urandom_range(sb.head_lanes + 2))
                                            : 12'($urandom_range(4094));
            send_pair(lane, 12'($urandom_range(4095)), pick_value(), pick_value(),
                      pick_value(), pick_value());
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed beats at reset settings
        send_pair(12'd0, 12'd0, 32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_pair(12'd0, 12'd1, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        send_pair(12'd0, 12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000);
        send_pair(12'd1, 12'd100, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 32'h8765_4321);
        send_pair(12'd63, 12'd4095, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_pair(12'd64, 12'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        send_pair(12'd4094, 12'd4095, 32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555,
                  32'hAAAA_AAAA);
        send_pair(12'd2, 12'd2048, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
        for (int p = 0; p < 8; p++)
            send_pair(12'd0, 12'(p), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        settings++;
        random_items(RAND_ITEMS);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_HEAD_LANES, 13'd0); write_reg(REG_KEY_WIDTH, 13'h1FFF); end
                1: begin write_reg(REG_HEAD_LANES, 13'd2); write_reg(REG_KEY_WIDTH, 13'd2); end
                2: begin write_reg(REG_HEAD_LANES, 13'h1FFF); write_reg(REG_KEY_WIDTH, 13'd0); end
                3: begin write_reg(REG_HEAD_LANES, 13'd256); write_reg(REG_KEY_WIDTH, 13'd1000); end
                default: begin write_reg(REG_HEAD_LANES, 13'd7); write_reg(REG_KEY_WIDTH, 13'd4096); end
            endcase
            settings++;
            quiet = (ph == 1);
            if (ph == 2)
                send_pair(12'd2, 12'd4095, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h2);
            random_items(RAND_ITEMS);
            drain();
            quiet = 1'b0;
        end

        while (sb.pending_pairs.size() != 0)
            sb.report("missing beat", 0, longint'(sb.pending_pairs.pop_front()));
        $display("%0d pairs sent, %0d results checked, %0d register settings",
                 sent, sb.matched, settings);
        if (sb.errors == 0)
            $display("rotary_position_rotate_tb passed");
        else
            $display("rotary_position_rotate_tb failed");
        $finish;
    end
endmodule
